// File: rtl/pmrs_pkg.sv
// Shared types, codes and constants of the power monitor reading scaler.
package pmrs_pkg;

  localparam int unsigned OpW      = 4;
  localparam int unsigned RawW     = 24;
  localparam int unsigned UserW    = 32;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned ValW     = 48;
  localparam int unsigned WordW    = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TempShift = 4;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MaxCurW  = 31;
  localparam int unsigned ShuntW   = 32;

  localparam int unsigned LsbW     = 17;
  localparam int unsigned PwrLsbW  = 14;
  localparam int unsigned LimLsbW  = 22;
  localparam int unsigned CalLsbW  = 16;
  localparam int unsigned CalcW    = 32;

  localparam int unsigned OpndW    = 32;
  localparam int unsigned DivW     = 22;
  localparam int unsigned NumW     = 52;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned NumDivStages = NumW / BitsPerStage;

  localparam logic [MaxCurW-1:0] MaxCurRst = 31'd16000000;
  localparam logic [ShuntW-1:0]  ShuntRst  = 32'd2000;

  localparam int unsigned CurLsbRound = 16384;
  localparam int unsigned CurLsbShift = 15;
  localparam int unsigned PwrShift    = 1;
  localparam int unsigned PwrRoundAdd = 5;
  localparam int unsigned LimShift    = 9;
  localparam int unsigned CalScale    = 819;
  localparam int unsigned CalRoundAdd = 500;

  localparam logic [CalcW-1:0] Div10Magic   = 32'hCCCC_CCCD;
  localparam int unsigned      Div10Shift   = 35;
  localparam logic [CalcW-1:0] Div1000Magic = 32'h1062_4DD3;
  localparam int unsigned      Div1000Shift = 38;

  localparam logic [OpndW-1:0] MulTemp        = 32'd125;
  localparam logic [OpndW-1:0] MulShuntFine   = 32'd1250;
  localparam logic [OpndW-1:0] MulShuntCoarse = 32'd5000;
  localparam logic [OpndW-1:0] MulBus         = 32'd3125;
  localparam logic [OpndW-1:0] MulKilo        = 32'd1000;
  localparam logic [OpndW-1:0] MulMega        = 32'd1000000;

  localparam logic [DivW-1:0] DivUnit = 22'd1;
  localparam logic [DivW-1:0] DivKilo = 22'd1000;
  localparam logic [DivW-1:0] DivMega = 22'd1000000;
  localparam logic [DivW-1:0] DivBus  = 22'd3125;

  typedef enum logic [OpW-1:0] {
    OpTemp     = 4'd0,
    OpShunt    = 4'd1,
    OpBus      = 4'd2,
    OpCurrent  = 4'd3,
    OpPower    = 4'd4,
    OpPwrLimit = 4'd5,
    OpBusLimWr = 4'd6,
    OpPwrLimWr = 4'd7,
    OpCal      = 4'd8
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxCurrent = 2'd0,
    RegShuntRes   = 2'd1,
    RegFineRange  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StepLsb,
    StepScale,
    StepDivide,
    StepDone
  } cal_step_e;

  typedef struct packed {
    logic [LsbW-1:0]    cur_lsb;
    logic [PwrLsbW-1:0] pwr_lsb;
    logic [LimLsbW-1:0] lim_lsb;
    logic [CalLsbW-1:0] cal_lsb;
    logic [ShuntW-1:0]  shunt_res;
    logic               fine_range;
  } scale_t;

  typedef struct packed {
    logic            neg;
    logic            wr16;
    logic            err;
    logic [DivW-1:0] divisor;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [OpndW-1:0] mag;
    logic [OpndW-1:0] mult;
  } cmd_t;

endpackage

// File: rtl/pmrs_cfg.sv
// Configuration registers and derivation of the current, power, limit and calibration LSBs.
module pmrs_cfg import pmrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output scale_t              scale_o,
  output logic                busy_o
);

  logic                 cfg_we;
  logic [MaxCurW-1:0]   max_cur_q;
  logic [ShuntW-1:0]    shunt_q;
  logic                 fine_q;
  cal_step_e            step_q, step_d;

  logic [MaxCurW:0]     lsb_sum;
  logic [LsbW-1:0]      lsb_d, lsb_q;
  logic [CalcW-1:0]     pl_x_d, pl_x_q;
  logic [CalcW-1:0]     ql_x_d, ql_x_q;
  logic [CalcW-1:0]     cal_x_d, cal_x_q;
  logic [2*CalcW-1:0]   pl_prod, ql_prod, cal_prod;
  logic [PwrLsbW-1:0]   pwr_lsb_q;
  logic [LimLsbW-1:0]   lim_lsb_q;
  logic [CalLsbW-1:0]   cal_lsb_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cur_q <= MaxCurRst;
      shunt_q   <= ShuntRst;
      fine_q    <= 1'b0;
      step_q    <= StepLsb;
    end else begin
      step_q <= step_d;
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index_i))
          RegMaxCurrent: max_cur_q <= cfg_data_i[MaxCurW-1:0];
          RegShuntRes:   shunt_q   <= cfg_data_i[ShuntW-1:0];
          RegFineRange:  fine_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    step_d = step_q;
    case (step_q)
      StepLsb:    step_d = StepScale;
      StepScale:  step_d = StepDivide;
      StepDivide: step_d = StepDone;
      StepDone:   step_d = StepDone;
      default:    step_d = StepLsb;
    endcase
    if (cfg_we) begin
      step_d = StepLsb;
    end
  end

  always_comb begin
    busy_o = (step_q != StepDone);
  end

  assign lsb_sum = {1'b0, max_cur_q} + (MaxCurW+1)'(CurLsbRound);
  assign lsb_d   = lsb_sum[CurLsbShift +: LsbW];

  assign pl_x_d  = (CalcW'(lsb_q) << PwrShift) + CalcW'(PwrRoundAdd);
  assign ql_x_d  = (CalcW'(lsb_q) << LimShift) + CalcW'(PwrRoundAdd);
  assign cal_x_d = CalcW'(lsb_q) * CalcW'(CalScale) + CalcW'(CalRoundAdd);

  assign pl_prod  = {{CalcW{1'b0}}, pl_x_q}  * {{CalcW{1'b0}}, Div10Magic};
  assign ql_prod  = {{CalcW{1'b0}}, ql_x_q}  * {{CalcW{1'b0}}, Div10Magic};
  assign cal_prod = {{CalcW{1'b0}}, cal_x_q} * {{CalcW{1'b0}}, Div1000Magic};

  always_ff @(posedge clk_i) begin
    if (step_q == StepLsb) begin
      lsb_q <= lsb_d;
    end
    if (step_q == StepScale) begin
      pl_x_q  <= pl_x_d;
      ql_x_q  <= ql_x_d;
      cal_x_q <= cal_x_d;
    end
    if (step_q == StepDivide) begin
      pwr_lsb_q <= pl_prod[Div10Shift +: PwrLsbW];
      lim_lsb_q <= ql_prod[Div10Shift +: LimLsbW];
      cal_lsb_q <= cal_prod[Div1000Shift +: CalLsbW];
    end
  end

  assign scale_o.cur_lsb    = lsb_q;
  assign scale_o.pwr_lsb    = pwr_lsb_q;
  assign scale_o.lim_lsb    = lim_lsb_q;
  assign scale_o.cal_lsb    = cal_lsb_q;
  assign scale_o.shunt_res  = shunt_q;
  assign scale_o.fine_range = fine_q;

endmodule

// File: rtl/pmrs_front.sv
// Input acceptance and decoding of each word into multiplier and divider operands.
module pmrs_front import pmrs_pkg::*; (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,
  input  logic [OpW-1:0]     s_axis_tuser_i,
  input  scale_t             scale_i,
  input  logic               busy_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [SampleW-1:0] w;
  logic [RawW-1:0]    raw;
  logic [UserW-1:0]   user;
  logic               s_neg;
  logic [SampleW-1:0] s_mag;
  logic               u_neg;
  logic [UserW-1:0]   u_mag;

  assign s_axis_tready_o = ~busy_i & ~q_full_i;
  assign push_o          = s_axis_tvalid_i & s_axis_tready_o;

  assign raw   = s_axis_tdata_i[RawW-1:0];
  assign user  = s_axis_tdata_i[RawW +: UserW];
  assign w     = raw[SampleW-1:0];
  assign s_neg = w[SampleW-1];
  assign s_mag = s_neg ? SampleW'(~w + SampleW'(1)) : w;
  assign u_neg = user[UserW-1];
  assign u_mag = u_neg ? UserW'(~user + UserW'(1)) : user;

  always_comb begin
    cmd_o             = '0;
    cmd_o.tag.divisor = DivUnit;
    case (op_e'(s_axis_tuser_i))
      OpTemp: begin
        cmd_o.mag  = OpndW'(w[SampleW-1:TempShift]);
        cmd_o.mult = MulTemp;
      end
      OpShunt: begin
        cmd_o.mag         = OpndW'(s_mag);
        cmd_o.mult        = scale_i.fine_range ? MulShuntFine : MulShuntCoarse;
        cmd_o.tag.divisor = DivKilo;
        cmd_o.tag.neg     = s_neg;
      end
      OpBus: begin
        cmd_o.mag         = OpndW'(s_mag);
        cmd_o.mult        = MulBus;
        cmd_o.tag.divisor = DivKilo;
        cmd_o.tag.neg     = s_neg;
      end
      OpCurrent: begin
        cmd_o.mag         = OpndW'(s_mag);
        cmd_o.mult        = OpndW'(scale_i.cur_lsb);
        cmd_o.tag.divisor = DivKilo;
        cmd_o.tag.neg     = s_neg;
      end
      OpPower: begin
        cmd_o.mag         = OpndW'(raw);
        cmd_o.mult        = OpndW'(scale_i.pwr_lsb);
        cmd_o.tag.divisor = DivMega;
      end
      OpPwrLimit: begin
        cmd_o.mag         = OpndW'(w);
        cmd_o.mult        = OpndW'(scale_i.lim_lsb);
        cmd_o.tag.divisor = DivMega;
      end
      OpBusLimWr: begin
        cmd_o.mag         = OpndW'(u_mag);
        cmd_o.mult        = MulKilo;
        cmd_o.tag.divisor = DivBus;
        cmd_o.tag.neg     = u_neg;
        cmd_o.tag.wr16    = 1'b1;
      end
      OpPwrLimWr: begin
        if (scale_i.lim_lsb == '0) begin
          cmd_o.tag.err = 1'b1;
        end else begin
          cmd_o.mag         = OpndW'(u_mag);
          cmd_o.mult        = MulMega;
          cmd_o.tag.divisor = DivW'(scale_i.lim_lsb);
          cmd_o.tag.neg     = u_neg;
          cmd_o.tag.wr16    = 1'b1;
        end
      end
      OpCal: begin
        cmd_o.mag         = OpndW'(scale_i.cal_lsb);
        cmd_o.mult        = OpndW'(scale_i.shunt_res);
        cmd_o.tag.divisor = DivKilo;
        cmd_o.tag.wr16    = 1'b1;
      end
      default: begin
        cmd_o.mag  = '0;
        cmd_o.mult = '0;
      end
    endcase
  end

endmodule

// File: rtl/pmrs_fifo.sv
// Short command queue between the decode front and the arithmetic back end.
module pmrs_fifo import pmrs_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_d;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

// File: rtl/pmrs_back.sv
// Multiply, round, pipelined long division and sign/word formatting of each command.
module pmrs_back import pmrs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  cmd_t            q_cmd_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [ValW-1:0] m_axis_tdata_o,
  output logic            m_axis_tuser_o
);

  localparam int unsigned Last = NumDivStages - 1;

  function automatic logic [DivW+NumW-1:0] div_step(
    logic [DivW-1:0] rem,
    logic [NumW-1:0] nq,
    logic [DivW-1:0] dvs
  );
    logic [DivW:0] trial;
    logic [DivW:0] diff;
    logic          qbit;
    trial = {rem, nq[NumW-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
    return {(qbit ? diff[DivW-1:0] : trial[DivW-1:0]), nq[NumW-2:0], qbit};
  endfunction

  logic                   adv;
  logic [2*OpndW-1:0]     prod;

  logic                   m_vld_q;
  logic [NumW-1:0]        m_prod_q;
  tag_t                   m_tag_q;
  logic                   h_vld_q;
  logic [NumW-1:0]        h_num_q;
  tag_t                   h_tag_q;

  logic [NumDivStages-1:0] d_vld_q;
  logic [DivW-1:0]         d_rem_q [NumDivStages];
  logic [NumW-1:0]         d_nq_q  [NumDivStages];
  tag_t                    d_tag_q [NumDivStages];

  logic [DivW-1:0]         stg_rem_in [NumDivStages];
  logic [NumW-1:0]         stg_nq_in  [NumDivStages];
  tag_t                    stg_tag_in [NumDivStages];
  logic [DivW+NumW-1:0]    stg_mid    [NumDivStages];
  logic [DivW+NumW-1:0]    stg_res    [NumDivStages];

  logic [ValW-1:0]         quo;
  logic [ValW-1:0]         signed_val;
  logic [ValW-1:0]         out_d;
  logic                    out_vld_q;
  logic [ValW-1:0]         out_data_q;
  logic                    out_err_q;

  assign adv     = ~out_vld_q | m_axis_tready_i;
  assign q_pop_o = q_valid_i & adv;
  assign prod    = {{OpndW{1'b0}}, q_cmd_i.mag} * {{OpndW{1'b0}}, q_cmd_i.mult};

  always_comb begin
    stg_rem_in[0] = '0;
    stg_nq_in[0]  = h_num_q;
    stg_tag_in[0] = h_tag_q;
    for (int i = 1; i < NumDivStages; i++) begin
      stg_rem_in[i] = d_rem_q[i-1];
      stg_nq_in[i]  = d_nq_q[i-1];
      stg_tag_in[i] = d_tag_q[i-1];
    end
    for (int i = 0; i < NumDivStages; i++) begin
      stg_mid[i] = div_step(stg_rem_in[i], stg_nq_in[i], stg_tag_in[i].divisor);
      stg_res[i] = div_step(stg_mid[i][NumW +: DivW], stg_mid[i][NumW-1:0],
                            stg_tag_in[i].divisor);
    end
  end

  assign quo        = d_nq_q[Last][ValW-1:0];
  assign signed_val = d_tag_q[Last].neg ? (~quo + ValW'(1)) : quo;
  assign out_d      = d_tag_q[Last].wr16 ? ValW'(signed_val[WordW-1:0]) : signed_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      d_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q   <= q_valid_i;
      h_vld_q   <= m_vld_q;
      d_vld_q   <= {d_vld_q[NumDivStages-2:0], h_vld_q};
      out_vld_q <= d_vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_prod_q <= prod[NumW-1:0];
      m_tag_q  <= q_cmd_i.tag;
      h_num_q  <= m_prod_q + NumW'(m_tag_q.divisor >> 1);
      h_tag_q  <= m_tag_q;
      for (int i = 0; i < NumDivStages; i++) begin
        d_rem_q[i] <= stg_res[i][NumW +: DivW];
        d_nq_q[i]  <= stg_res[i][NumW-1:0];
        d_tag_q[i] <= stg_tag_in[i];
      end
      out_data_q <= out_d;
      out_err_q  <= d_tag_q[Last].err;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_err_q;

endmodule

// File: rtl/power_monitor_reading_scaler.sv
// Throughput: one word per cycle unless a recompute, a full queue or an m_axis
// stall holds the flow; the 26-stage divider (two quotient bits a stage) and
// the 32x32 multiplier each take a new operand set every cycle without a stall.
// Reset: configuration returns to its defaults and all valid flags clear; after
// reset and each config write s_axis_tready_o stays low in StepLsb, StepScale,
// StepDivide, as the current, power, limit and calibration LSBs are recomputed.
module power_monitor_reading_scaler import pmrs_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // raw_word[23:0], user_value[55:24]
  input  logic [OpW-1:0]      s_axis_tuser_i,   // op[3:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ValW-1:0]     m_axis_tdata_o,   // scaled_value[47:0]
  output logic                m_axis_tuser_o    // divide_error[0]
);

  scale_t scale;
  logic   busy;
  logic   q_full;
  logic   push;
  cmd_t   push_cmd;
  logic   q_valid;
  logic   q_pop;
  cmd_t   q_cmd;

  pmrs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .scale_o     (scale),
    .busy_o      (busy)
  );

  pmrs_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .scale_i         (scale),
    .busy_i          (busy),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  pmrs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  pmrs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// File: rtl/pmrs_checker.sv
// Port-level checks of the reading scaler and their binding to the top level.
module pmrs_checker import pmrs_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_valid_i,
  input logic            cfg_ready_o,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [ValW-1:0] m_axis_tdata_o,
  input logic            m_axis_tuser_o
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("divide error with nonzero value");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready_o)
    else $error("input accepted before LSBs were recomputed");

endmodule

bind power_monitor_reading_scaler pmrs_checker u_checker (.*);
